// ===== rtl/qlu_pkg.sv =====
// Shared types, constants and the control program of the Q-learning update unit.
// Depends on nothing; every other file of the block but qlu_ram imports it.
package qlu_pkg;

    // Table geometry defaults
    localparam int QLU_NUM_STATES  = 4;
    localparam int QLU_NUM_ACTIONS = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_DISCOUNT = 3'd0;
    localparam logic [2:0] REG_RATE     = 3'd1;
    localparam logic [2:0] REG_REWARD0  = 3'd2;
    localparam logic [2:0] REG_REWARD1  = 3'd3;
    localparam logic [2:0] REG_REWARD2  = 3'd4;
    localparam logic [2:0] REG_REWARD3  = 3'd5;
    localparam logic [2:0] REG_MASK     = 3'd6;

    // Register reset values
    localparam logic [3:0]  RST_DISCOUNT = 4'd8;
    localparam logic [3:0]  RST_RATE     = 4'd5;
    localparam logic [15:0] RST_REWARD0  = 16'd1000;
    localparam logic [15:0] RST_REWARD1  = 16'hFFF6;   // -10
    localparam logic [15:0] RST_REWARD2  = 16'hFF06;   // -250
    localparam logic [15:0] RST_REWARD3  = 16'hFE0C;   // -500
    localparam logic [15:0] RST_MASK     = 16'hF731;

    // Arithmetic constants
    localparam logic signed [23:0] QLU_MAX_FLOOR = -24'sd100;
    localparam logic signed [27:0] QLU_SUM_MAX   = 28'sd8388607;
    localparam logic signed [27:0] QLU_SUM_MIN   = -28'sd8388608;
    // ceil(2^33 / 10): exact truncating divide by ten for magnitudes below 2^29
    localparam logic [29:0]        QLU_RECIP10   = 30'd858993460;

    // Configuration bundle handed to the datapath
    typedef struct packed {
        logic [3:0]       disc;
        logic [3:0]       rate;
        logic [3:0][15:0] reward;
        logic [15:0]      mask;
    } cfg_t;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_DISC,
        OP_RECIP,
        OP_DELTA,
        OP_MUL_RATE,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    // What the read issued in this step feeds in the next cycle
    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_MAX,
        TAG_CUR,
        TAG_ARG
    } tag_t;

    typedef enum logic {
        RSEL_ROW,
        RSEL_CUR
    } rsel_t;

    // Sequencer branch conditions
    typedef enum logic [2:0] {
        JC_NEXT,      // advance
        JC_GOTO,      // jump to target
        JC_IN_WAIT,   // hold until an input item is offered, then advance
        JC_ACT_MORE,  // jump to target while actions remain, else advance
        JC_OUT_FREE   // hold while the result register is blocked, else jump
    } jc_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_WAIT   = 4'd0;
    localparam step_t ST_RDMAX  = 4'd1;
    localparam step_t ST_RDCUR  = 4'd2;
    localparam step_t ST_MULD   = 4'd3;
    localparam step_t ST_DIV1   = 4'd4;
    localparam step_t ST_DELTA  = 4'd5;
    localparam step_t ST_MULR   = 4'd6;
    localparam step_t ST_DIV2   = 4'd7;
    localparam step_t ST_UPDATE = 4'd8;
    localparam step_t ST_RDARG  = 4'd9;
    localparam step_t ST_DRAIN  = 4'd10;
    localparam step_t ST_EMIT   = 4'd11;

    typedef struct packed {
        op_t   op;
        rsel_t rsel;
        tag_t  tag;
        jc_t   jc;
        step_t target;
    } uword_t;

    // Controls from sequencer to datapath
    typedef struct packed {
        op_t   op;
        rsel_t rsel;
        tag_t  tag;
    } ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_valid;
        logic out_full;
    } stat_t;

    function automatic uword_t qlu_cw(input op_t op, input rsel_t rsel, input tag_t tag,
                                      input jc_t jc, input step_t target);
        uword_t w;
        w.op     = op;
        w.rsel   = rsel;
        w.tag    = tag;
        w.jc     = jc;
        w.target = target;
        return w;
    endfunction

    // Control program
    function automatic uword_t qlu_ucode(input step_t step);
        uword_t w;
        unique case (step)
            ST_WAIT:   w = qlu_cw(OP_LOAD,     RSEL_ROW, TAG_NONE, JC_IN_WAIT,  ST_WAIT);
            ST_RDMAX:  w = qlu_cw(OP_NONE,     RSEL_ROW, TAG_MAX,  JC_ACT_MORE, ST_RDMAX);
            ST_RDCUR:  w = qlu_cw(OP_NONE,     RSEL_CUR, TAG_CUR,  JC_NEXT,     ST_WAIT);
            ST_MULD:   w = qlu_cw(OP_MUL_DISC, RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_DIV1:   w = qlu_cw(OP_RECIP,    RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_DELTA:  w = qlu_cw(OP_DELTA,    RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_MULR:   w = qlu_cw(OP_MUL_RATE, RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_DIV2:   w = qlu_cw(OP_RECIP,    RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_UPDATE: w = qlu_cw(OP_UPDATE,   RSEL_CUR, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_RDARG:  w = qlu_cw(OP_NONE,     RSEL_ROW, TAG_ARG,  JC_ACT_MORE, ST_RDARG);
            ST_DRAIN:  w = qlu_cw(OP_NONE,     RSEL_ROW, TAG_NONE, JC_NEXT,     ST_WAIT);
            ST_EMIT:   w = qlu_cw(OP_EMIT,     RSEL_ROW, TAG_NONE, JC_OUT_FREE, ST_WAIT);
            default:   w = qlu_cw(OP_NONE,     RSEL_ROW, TAG_NONE, JC_GOTO,     ST_WAIT);
        endcase
        return w;
    endfunction

    // Clamp a 2 bit index to limit-1
    function automatic logic [1:0] qlu_clamp(input logic [1:0] v, input int limit);
        return (int'(v) >= limit) ? 2'(limit - 1) : v;
    endfunction

endpackage

// ===== rtl/qlu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used by the Q-learning datapath for the Q table.
module qlu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/qlu_seq.sv =====
// Microcode sequencer: step counter, action loop counter and control program fetch.
// Depends on qlu_pkg for the program table and control types.
module qlu_seq
    import qlu_pkg::*;
#(
    parameter int NUM_ACTIONS = QLU_NUM_ACTIONS,
    localparam int ACT_W      = $clog2(NUM_ACTIONS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stat_t            stat,
    output ctrl_t            ctrl,
    output logic [ACT_W-1:0] act
);

    localparam logic [ACT_W-1:0] ACT_LAST = ACT_W'(NUM_ACTIONS - 1);

    step_t            step_reg, step_next;
    logic [ACT_W-1:0] act_reg, act_next;
    uword_t           word;

    // Fetch the control word of the current step
    assign word      = qlu_ucode(step_reg);
    assign ctrl.op   = word.op;
    assign ctrl.rsel = word.rsel;
    assign ctrl.tag  = word.tag;
    assign act       = act_reg;

    // Branch on the word's condition
    always_comb
    begin
        step_next = step_reg + 4'd1;
        act_next  = act_reg;
        unique case (word.jc)
            JC_NEXT:
            begin
            end
            JC_GOTO:
            begin
                step_next = word.target;
            end
            JC_IN_WAIT:
            begin
                if (!stat.in_valid)
                begin
                    step_next = step_reg;
                end
            end
            JC_ACT_MORE:
            begin
                if (act_reg != ACT_LAST)
                begin
                    step_next = word.target;
                    act_next  = act_reg + 1'b1;
                end
                else
                begin
                    act_next = '0;
                end
            end
            JC_OUT_FREE:
            begin
                step_next = stat.out_full ? step_reg : word.target;
            end
            default:
            begin
                step_next = ST_WAIT;
            end
        endcase
    end

    // Hold step and loop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
            act_reg  <= '0;
        end
        else
        begin
            step_reg <= step_next;
            act_reg  <= act_next;
        end
    end

endmodule

// ===== rtl/qlu_datapath.sv =====
// Datapath of the Q-learning update: Q table RAM with valid bits, row max,
// scaled update with a divide-by-ten unit, argmax and the result register.
// Depends on qlu_pkg and qlu_ram.
module qlu_datapath
    import qlu_pkg::*;
#(
    parameter int NUM_STATES  = QLU_NUM_STATES,
    parameter int NUM_ACTIONS = QLU_NUM_ACTIONS,
    localparam int ACT_W      = $clog2(NUM_ACTIONS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  ctrl_t            ctrl,
    input  logic [ACT_W-1:0] act,
    output stat_t            stat,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata
);

    localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(NUM_STATES);

    // Item indexes
    logic [SW-1:0]    ls_reg, ns_reg;
    logic [ACT_W-1:0] la_reg;

    // RAM access
    logic [AW-1:0]    row_addr, cur_addr, raddr;
    logic             re, we;
    logic [23:0]      ram_rdata;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    tag_t             tag_reg;
    logic [ACT_W-1:0] tag_act_reg;
    logic signed [23:0] rd_q;

    // Arithmetic
    logic signed [23:0] best_reg, cur_reg, nv_reg, nv_next;
    logic signed [29:0] prod_reg, neg_prod;
    logic signed [28:0] pd;
    logic signed [30:0] pr;
    logic [28:0]        mag;
    logic [58:0]        mp;
    logic [25:0]        recip_reg;
    logic               neg_reg;
    logic signed [26:0] quot, delta_sum;
    logic signed [25:0] delta_reg;
    logic signed [27:0] upd_sum;
    logic [15:0]        rw;

    // Choice and result
    logic [ACT_W-1:0]   pick_reg;
    logic signed [23:0] pick_val_reg;
    logic               allowed;
    logic               accept, emit;
    logic               out_valid_reg;
    logic [1:0]         out_action_reg;
    logic [23:0]        out_value_reg;

    // Handshake and status
    assign s_tready      = (ctrl.op == OP_LOAD);
    assign accept        = s_tvalid && s_tready;
    assign stat.in_valid = s_tvalid;
    assign stat.out_full = out_valid_reg && !m_tready;
    assign emit          = (ctrl.op == OP_EMIT) && !stat.out_full;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {6'd0, out_value_reg, out_action_reg};

    // Table addresses
    assign row_addr = AW'(int'(ns_reg) * NUM_ACTIONS + int'(act));
    assign cur_addr = AW'(int'(ls_reg) * NUM_ACTIONS + int'(la_reg));
    assign raddr    = (ctrl.rsel == RSEL_CUR) ? cur_addr : row_addr;
    assign re       = (ctrl.tag != TAG_NONE);
    assign we       = (ctrl.op == OP_UPDATE);

    qlu_ram #(
        .WIDTH (24),
        .DEPTH (DEPTH)
    ) u_qtab (
        .clk   (clk),
        .we    (we),
        .waddr (cur_addr),
        .wdata (nv_next),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Entries never written read as zero
    assign rd_q    = rd_valid_reg ? $signed(ram_rdata) : 24'sd0;
    assign allowed = cfg.mask[{2'(ns_reg), 2'(tag_act_reg)}];
    assign rw      = cfg.reward[2'(ns_reg)];

    // Multiply, divide-by-ten and update arithmetic
    always_comb
    begin
        pd        = $signed({1'b0, cfg.disc}) * best_reg;
        pr        = $signed({1'b0, cfg.rate}) * delta_reg;
        neg_prod  = -prod_reg;
        mag       = prod_reg[29] ? neg_prod[28:0] : prod_reg[28:0];
        mp        = mag * QLU_RECIP10;
        quot      = neg_reg ? -$signed({1'b0, recip_reg}) : $signed({1'b0, recip_reg});
        delta_sum = $signed({{11{rw[15]}}, rw}) + quot
                    - $signed({{3{cur_reg[23]}}, cur_reg});
        upd_sum   = $signed({{4{cur_reg[23]}}, cur_reg}) + $signed({quot[26], quot});
        if (upd_sum > QLU_SUM_MAX)
        begin
            nv_next = 24'sh7FFFFF;
        end
        else if (upd_sum < QLU_SUM_MIN)
        begin
            nv_next = -24'sh800000;
        end
        else
        begin
            nv_next = upd_sum[23:0];
        end
    end

    // Control state: valid bits, read tag, row max and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            tag_reg       <= TAG_NONE;
            best_reg      <= QLU_MAX_FLOOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag_reg <= re ? ctrl.tag : TAG_NONE;
            if (we)
            begin
                valid_reg[cur_addr] <= 1'b1;
            end
            if (accept)
            begin
                best_reg <= QLU_MAX_FLOOR;
            end
            else if (tag_reg == TAG_MAX && rd_q > best_reg)
            begin
                best_reg <= rd_q;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[raddr];
        tag_act_reg  <= act;
        if (accept)
        begin
            ls_reg <= SW'(qlu_clamp(s_tdata[1:0], NUM_STATES));
            la_reg <= ACT_W'(qlu_clamp(s_tdata[3:2], NUM_ACTIONS));
            ns_reg <= SW'(qlu_clamp(s_tdata[5:4], NUM_STATES));
        end
        if (tag_reg == TAG_CUR)
        begin
            cur_reg <= rd_q;
        end
        if (tag_reg == TAG_ARG)
        begin
            if (tag_act_reg == '0)
            begin
                pick_reg     <= '0;
                pick_val_reg <= rd_q;
            end
            else if (allowed && pick_val_reg < rd_q)
            begin
                pick_reg     <= tag_act_reg;
                pick_val_reg <= rd_q;
            end
        end
        case (ctrl.op)
            OP_MUL_DISC: prod_reg <= {pd[28], pd};
            OP_MUL_RATE: prod_reg <= pr[29:0];
            OP_RECIP:
            begin
                recip_reg <= mp[58:33];
                neg_reg   <= prod_reg[29];
            end
            OP_DELTA:    delta_reg <= delta_sum[25:0];
            OP_UPDATE:   nv_reg <= nv_next;
            default:
            begin
            end
        endcase
        if (emit)
        begin
            out_action_reg <= 2'(pick_reg);
            out_value_reg  <= nv_reg;
        end
    end

    // The sequencer leaves the wait step right after an accepted item
    a_accept_leaves_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctrl.op != OP_LOAD)
        else $error("input accepted twice in a row");

    // A written entry reads back as valid
    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> valid_reg[$past(cur_addr)])
        else $error("valid bit not set after table write");

    // The chosen action is action zero or a permitted one
    a_pick_permitted: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (pick_reg == '0 || cfg.mask[{2'(ns_reg), 2'(pick_reg)}]))
        else $error("chosen action not permitted");

    // The running maximum never drops below its floor
    a_best_floor: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg >= QLU_MAX_FLOOR)
        else $error("row maximum below floor");

endmodule

// ===== rtl/q_learning_update.sv =====
// Top level of the tabular Q-learning update unit: configuration registers,
// sequencer and datapath. Depends on qlu_pkg, qlu_seq and qlu_datapath.
//
// One input item (previous state, previous action, arrived state) produces one
// result item (chosen action, new Q value). The control program carries it
// from acceptance to the result register with one RAM read per cycle for the
// row maximum and again for the argmax, one read of the current entry, one
// drain step, plus six arithmetic steps through the discount and rate
// multipliers and the shared divide-by-ten unit. Only one item is in work at
// a time; the sequencer returns to the wait step at the edge that loads the
// result into the output register, and a result that is not taken holds the
// next item in its emit step. The Q table clears at reset through per-entry
// valid bits, so no clearing pass is needed. Configuration writes are taken in
// any cycle and must only be issued while the block is idle.
module q_learning_update
    import qlu_pkg::*;
#(
    parameter int NUM_STATES  = QLU_NUM_STATES,
    parameter int NUM_ACTIONS = QLU_NUM_ACTIONS
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] prev_state, [3:2] prev_action, [5:4] arrived_state
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] chosen_action, [25:2] updated_value
);

    localparam int ACT_W = $clog2(NUM_ACTIONS);

    cfg_t             cfg_reg;
    ctrl_t            ctrl;
    stat_t            stat;
    logic [ACT_W-1:0] act;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.disc      <= RST_DISCOUNT;
            cfg_reg.rate      <= RST_RATE;
            cfg_reg.reward[0] <= RST_REWARD0;
            cfg_reg.reward[1] <= RST_REWARD1;
            cfg_reg.reward[2] <= RST_REWARD2;
            cfg_reg.reward[3] <= RST_REWARD3;
            cfg_reg.mask      <= RST_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DISCOUNT: cfg_reg.disc      <= cfg_data[3:0];
                REG_RATE:     cfg_reg.rate      <= cfg_data[3:0];
                REG_REWARD0:  cfg_reg.reward[0] <= cfg_data;
                REG_REWARD1:  cfg_reg.reward[1] <= cfg_data;
                REG_REWARD2:  cfg_reg.reward[2] <= cfg_data;
                REG_REWARD3:  cfg_reg.reward[3] <= cfg_data;
                REG_MASK:     cfg_reg.mask      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    qlu_seq #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .act   (act)
    );

    qlu_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ctrl     (ctrl),
        .act      (act),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
